// ===== design/swsr_pkg.sv =====
// Shared types and constants for the single-wire sensor reader.
package swsr_pkg;

  // Width of the configuration address and data buses
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes (byte address is four times the index)
  localparam logic [2:0] REG_START_LOW  = 3'd0;
  localparam logic [2:0] REG_START_HIGH = 3'd1;
  localparam logic [2:0] REG_RESP_WAIT  = 3'd2;
  localparam logic [2:0] REG_RESP_PHASE = 3'd3;
  localparam logic [2:0] REG_BIT_SAMPLE = 3'd4;

  // Register reset values
  localparam logic [15:0] START_LOW_RST  = 16'd10000;
  localparam logic [7:0]  START_HIGH_RST = 8'd30;
  localparam logic [7:0]  RESP_WAIT_RST  = 8'd40;
  localparam logic [7:0]  RESP_PHASE_RST = 8'd80;
  localparam logic [7:0]  BIT_SAMPLE_RST = 8'd30;

  // Saturation value of the tick counter
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_LOW      = 4'd1,
    PH_HIGH     = 4'd2,
    PH_ANS_LOW  = 4'd3,
    PH_ANS_HIGH = 4'd4,
    PH_ANS_TAIL = 4'd5,
    PH_BIT_RISE = 4'd6,
    PH_BIT_WAIT = 4'd7,
    PH_BIT_FALL = 4'd8
  } phase_t;

  // Event codes carried by each result
  typedef enum logic [1:0] {
    EVT_NONE     = 2'd0,
    EVT_ANS_OK   = 2'd1,
    EVT_ANS_FAIL = 2'd2,
    EVT_BYTE     = 2'd3
  } evt_t;

  // Timing configuration handed from the register block to the sequencer
  typedef struct packed {
    logic [15:0] start_low_us;
    logic [7:0]  start_high_us;
    logic [7:0]  response_wait_us;
    logic [7:0]  response_phase_us;
    logic [7:0]  bit_sample_us;
  } cfg_t;

endpackage

// ===== design/swsr_tick_if.sv =====
// Valid/ready channel carrying one microsecond tick request.
interface swsr_tick_if;
  logic valid;
  logic ready;
  logic line_level;
  logic start_request;

  modport source (output valid, output line_level, output start_request, input ready);
  modport sink   (input valid, input line_level, input start_request, output ready);
endinterface

// ===== design/swsr_result_if.sv =====
// Valid/ready channel carrying one result request per tick.
interface swsr_result_if;
  logic       valid;
  logic       ready;
  logic       drive_enable;
  logic       drive_level;
  logic [1:0] event_code;
  logic [7:0] byte_value;
  logic       last_byte;
  logic       busy_res;

  modport source (
    output valid, output drive_enable, output drive_level, output event_code,
    output byte_value, output last_byte, output busy_res, input ready
  );
  modport sink (
    input valid, input drive_enable, input drive_level, input event_code,
    input byte_value, input last_byte, input busy_res, output ready
  );
endinterface

// ===== design/swsr_cfg_regs.sv =====
// APB-style timing register block of the single-wire sensor reader.
module swsr_cfg_regs
  import swsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_us      <= START_LOW_RST;
      cfg.start_high_us     <= START_HIGH_RST;
      cfg.response_wait_us  <= RESP_WAIT_RST;
      cfg.response_phase_us <= RESP_PHASE_RST;
      cfg.bit_sample_us     <= BIT_SAMPLE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_LOW:  cfg.start_low_us      <= pwdata[15:0];
        REG_START_HIGH: cfg.start_high_us     <= pwdata[7:0];
        REG_RESP_WAIT:  cfg.response_wait_us  <= pwdata[7:0];
        REG_RESP_PHASE: cfg.response_phase_us <= pwdata[7:0];
        REG_BIT_SAMPLE: cfg.bit_sample_us     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      REG_START_LOW:  prdata = {16'd0, cfg.start_low_us};
      REG_START_HIGH: prdata = {24'd0, cfg.start_high_us};
      REG_RESP_WAIT:  prdata = {24'd0, cfg.response_wait_us};
      REG_RESP_PHASE: prdata = {24'd0, cfg.response_phase_us};
      REG_BIT_SAMPLE: prdata = {24'd0, cfg.bit_sample_us};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== design/single_wire_sensor_reader.sv =====
// Top level of the single-wire sensor reader: tick sequencer and result register.
//
// Usage: feed one request on the tick channel for every microsecond. Each tick
// carries the sensed line level and a start request. A start request while idle
// begins a transaction: the line is driven low for start_low_us ticks, driven
// high for start_high_us ticks, then released while the sensor answer is
// checked. After a good answer BYTES_PER_FRAME bytes are read MSB first.
// Every accepted tick yields exactly one result request on the result channel,
// showing the line drive for the next tick, an event code, a received byte,
// a last-byte mark and the busy flag.
// Output: each result is registered and appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle while results are taken; the whole per-tick
// update is one pass through the phase, counter and shift register logic.
// Stalls: the result register holds its request while the receiver stalls;
// a new tick is taken in the same cycle that the held result is taken.
// Reset (synchronous, active high) returns the sequencer to idle, clears the
// counters, empties the result register, and restores the timing registers.
// Timing registers must be written over the APB-style port while idle; unchecked.
module single_wire_sensor_reader
  import swsr_pkg::*;
#(
  parameter int unsigned BYTES_PER_FRAME = 5
) (
  input  logic              clk,
  input  logic              rst,
  swsr_tick_if.sink         tick,
  swsr_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [2:0] LAST_BYTE_IDX = 3'(BYTES_PER_FRAME - 1);

  cfg_t cfg;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next, tick_inc;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [2:0]  byte_index, byte_index_next;
  evt_t        evt_next;
  logic [7:0]  value_next;
  logic        last_next;
  logic        accept;

  swsr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A tick is taken whenever the result register is empty or being emptied.
  assign tick.ready = !result.valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  // Saturating count of the current tick within the phase.
  assign tick_inc = (tick_count == TICK_MAX) ? tick_count : tick_count + 16'd1;

  // Next phase, counters and shift register for this tick.
  always_comb begin
    logic bit_done;
    bit_done        = 1'b0;
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    byte_index_next = byte_index;
    evt_next        = EVT_NONE;
    value_next      = 8'd0;
    last_next       = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (tick.start_request) begin
          phase_next      = PH_LOW;
          tick_count_next = 16'd0;
        end
      end
      PH_LOW: begin
        tick_count_next = tick_inc;
        if (tick_inc >= cfg.start_low_us) begin
          phase_next      = PH_HIGH;
          tick_count_next = 16'd0;
        end
      end
      PH_HIGH: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {8'd0, cfg.start_high_us}) begin
          phase_next      = PH_ANS_LOW;
          tick_count_next = 16'd0;
        end
      end
      PH_ANS_LOW: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {8'd0, cfg.response_wait_us}) begin
          tick_count_next = 16'd0;
          if (!tick.line_level) begin
            phase_next = PH_ANS_HIGH;
          end else begin
            phase_next = PH_IDLE;
            evt_next   = EVT_ANS_FAIL;
          end
        end
      end
      PH_ANS_HIGH: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {8'd0, cfg.response_phase_us}) begin
          tick_count_next = 16'd0;
          if (tick.line_level) begin
            phase_next = PH_ANS_TAIL;
          end else begin
            phase_next = PH_IDLE;
            evt_next   = EVT_ANS_FAIL;
          end
        end
      end
      PH_ANS_TAIL: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {8'd0, cfg.response_phase_us}) begin
          evt_next        = EVT_ANS_OK;
          bit_index_next  = 3'd0;
          byte_index_next = 3'd0;
          phase_next      = PH_BIT_RISE;
          tick_count_next = 16'd0;
        end
      end
      PH_BIT_RISE: begin
        if (tick.line_level) begin
          phase_next      = PH_BIT_WAIT;
          tick_count_next = 16'd0;
        end
      end
      PH_BIT_WAIT: begin
        tick_count_next = tick_inc;
        if (tick_inc >= {8'd0, cfg.bit_sample_us}) begin
          shift_byte_next[3'd7 - bit_index] = tick.line_level;
          if (tick.line_level) begin
            phase_next      = PH_BIT_FALL;
            tick_count_next = 16'd0;
          end else begin
            bit_done = 1'b1;
          end
        end
      end
      PH_BIT_FALL: begin
        if (!tick.line_level) begin
          bit_done = 1'b1;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = 16'd0;
      end
    endcase

    // End of a data bit: advance the bit, and on the eighth report the byte.
    if (bit_done) begin
      tick_count_next = 16'd0;
      if (bit_index == 3'd7) begin
        evt_next       = EVT_BYTE;
        value_next     = shift_byte_next;
        last_next      = (byte_index == LAST_BYTE_IDX);
        bit_index_next = 3'd0;
        if (last_next) begin
          byte_index_next = 3'd0;
          phase_next      = PH_IDLE;
        end else begin
          byte_index_next = byte_index + 3'd1;
          phase_next      = PH_BIT_RISE;
        end
      end else begin
        bit_index_next = bit_index + 3'd1;
        phase_next     = PH_BIT_RISE;
      end
    end
  end

  // Sequencer state, updated once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 16'd0;
      bit_index  <= 3'd0;
      shift_byte <= 8'd0;
      byte_index <= 3'd0;
    end else if (accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      byte_index <= byte_index_next;
    end
  end

  // Result register: loaded on each accepted tick, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.drive_enable <= (phase_next == PH_LOW) || (phase_next == PH_HIGH);
      result.drive_level  <= (phase_next == PH_HIGH);
      result.event_code   <= evt_next;
      result.byte_value   <= value_next;
      result.last_byte    <= last_next;
      result.busy_res     <= (phase_next != PH_IDLE);
    end
  end

  // The counter is always cleared while idle.
  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_count == 16'd0))
    else $error("tick counter not clear while idle");

  // Without a start request an idle sequencer stays idle.
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_IDLE && !tick.start_request) |=> (phase == PH_IDLE))
    else $error("sequencer left idle without a start request");

  // The final byte ends the transaction on the same tick.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last_byte) |->
      (result.event_code == EVT_BYTE && !result.busy_res))
    else $error("last byte reported while still busy");

  // A driven high level is only shown while the line is driven.
  a_drive_level: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.drive_level) |-> (result.drive_enable && result.busy_res))
    else $error("drive level high while line released");

endmodule
